// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file bbn_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle check");

`endif

// ===== design/bbn_pkg.sv =====
package bbn_pkg;

  localparam int MaxWidth   = 256;
  localparam int Radius     = 4;
  localparam int WinSize    = 2 * Radius + 1;
  localparam int StoreRows  = 2 * Radius + 2;
  localparam int MinSize    = 16;

  localparam int DimW       = 9;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int SlotW      = $clog2(StoreRows);
  localparam int AddrW      = SlotW + ColW;
  localparam int StoreDepth = StoreRows * MaxWidth;
  localparam int ChanW      = 8;
  localparam int PixW       = 3 * ChanW;
  localparam int SumW       = $clog2(WinSize * WinSize * ((1 << ChanW) - 1) + 1);
  localparam int CntW       = $clog2(WinSize * WinSize + 1);
  localparam int RemW       = CntW + 1;
  localparam int TapW       = $clog2(WinSize);
  localparam int StepW      = $clog2(SumW);
  localparam int CfgIdxW    = 1;

  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 1'b1;

  localparam logic OpPixel = 1'b0;
  localparam logic OpDrain = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
    logic             last_of_frame;
  } out_item_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [PixW-1:0]  data;
  } store_wr_t;

  // One window job: output position, its store row slot, the frame size and the last-of-frame flag.
  typedef struct packed {
    logic [DimW-1:0]  row;
    logic [ColW-1:0]  col;
    logic [SlotW-1:0] slot;
    logic [DimW-1:0]  w;
    logic [DimW-1:0]  h;
    logic             last;
  } job_t;

  function automatic logic [SlotW-1:0] slot_inc(logic [SlotW-1:0] s);
    logic [SlotW-1:0] n;
    n = (s == SlotW'(StoreRows - 1)) ? '0 : s + SlotW'(1);
    return n;
  endfunction

endpackage

// ===== design/bbn_front.sv =====
module bbn_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [bbn_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bbn_pkg::DimW-1:0] cfg_data_i,
  input  logic                     push_i,
  input  bbn_pkg::in_item_t        item_i,
  input  logic                     hold_i,
  input  logic                     q_full_i,
  output logic                     full_o,
  output logic                     job_push_o,
  output bbn_pkg::job_t            job_o,
  output bbn_pkg::store_wr_t       wr_o
);
  import bbn_pkg::*;

  logic [DimW-1:0]  cfg_w_q, cfg_h_q, cur_w_q, cur_h_q, cur_w_d, cur_h_d;
  logic [DimW-1:0]  in_row_q, in_row_d, in_col_q, in_col_d;
  logic [DimW-1:0]  out_row_q, out_row_d, out_col_q, out_col_d;
  logic [SlotW-1:0] in_slot_q, in_slot_d, out_slot_q, out_slot_d;
  logic             done_q, done_d;
  logic             start, acc, pix, ready, emit, last;
  logic [DimW-1:0]  w_eff, h_eff;

  function automatic logic [DimW-1:0] clamp_w(logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v < DimW'(MinSize)) r = DimW'(MinSize);
    else if (v > DimW'(MaxWidth)) r = DimW'(MaxWidth);
    else r = v;
    return r;
  endfunction

  function automatic logic [DimW-1:0] clamp_h(logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = (v < DimW'(MinSize)) ? DimW'(MinSize) : v;
    return r;
  endfunction

  // New frame waits until the back end has stopped reading the store.
  assign start  = (in_row_q == '0) && (in_col_q == '0) && !done_q;
  assign full_o = q_full_i || (start && hold_i);
  assign acc    = push_i && !full_o;
  assign pix    = (item_i.opcode == OpPixel);
  assign w_eff  = start ? clamp_w(cfg_w_q) : cur_w_q;
  assign h_eff  = start ? clamp_h(cfg_h_q) : cur_h_q;
  assign ready  = (in_row_q > DimW'(Radius)) ||
                  ((in_row_q == DimW'(Radius)) && (in_col_q >= DimW'(Radius)));
  assign last   = (out_row_q == h_eff - DimW'(1)) && (out_col_q == w_eff - DimW'(1));
  assign emit   = acc && ((pix && !done_q && ready) || (!pix && done_q));

  always_comb begin
    cur_w_d    = cur_w_q;
    cur_h_d    = cur_h_q;
    in_row_d   = in_row_q;
    in_col_d   = in_col_q;
    in_slot_d  = in_slot_q;
    out_row_d  = out_row_q;
    out_col_d  = out_col_q;
    out_slot_d = out_slot_q;
    done_d     = done_q;
    if (acc && pix && !done_q) begin
      cur_w_d = w_eff;
      cur_h_d = h_eff;
      if (in_col_q + DimW'(1) >= w_eff) begin
        in_col_d = '0;
        if (in_row_q + DimW'(1) >= h_eff) begin
          done_d = 1'b1;
        end else begin
          in_row_d  = in_row_q + DimW'(1);
          in_slot_d = slot_inc(in_slot_q);
        end
      end else begin
        in_col_d = in_col_q + DimW'(1);
      end
    end
    if (emit) begin
      if (last) begin
        in_row_d   = '0;
        in_col_d   = '0;
        in_slot_d  = '0;
        out_row_d  = '0;
        out_col_d  = '0;
        out_slot_d = '0;
        done_d     = 1'b0;
      end else if (out_col_q + DimW'(1) >= w_eff) begin
        out_col_d  = '0;
        out_row_d  = out_row_q + DimW'(1);
        out_slot_d = slot_inc(out_slot_q);
      end else begin
        out_col_d = out_col_q + DimW'(1);
      end
    end
  end

  assign wr_o.en   = acc && pix && !done_q;
  assign wr_o.addr = {in_slot_q, in_col_q[ColW-1:0]};
  assign wr_o.data = {item_i.red_in, item_i.green_in, item_i.blue_in};

  assign job_push_o = emit;
  assign job_o.row  = out_row_q;
  assign job_o.col  = out_col_q[ColW-1:0];
  assign job_o.slot = out_slot_q;
  assign job_o.w    = w_eff;
  assign job_o.h    = h_eff;
  assign job_o.last = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q    <= DimW'(MaxWidth);
      cfg_h_q    <= DimW'(256);
      cur_w_q    <= DimW'(MinSize);
      cur_h_q    <= DimW'(MinSize);
      in_row_q   <= '0;
      in_col_q   <= '0;
      in_slot_q  <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_slot_q <= '0;
      done_q     <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == RegFrameWidth) cfg_w_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == RegFrameHeight) cfg_h_q <= cfg_data_i;
      cur_w_q    <= cur_w_d;
      cur_h_q    <= cur_h_d;
      in_row_q   <= in_row_d;
      in_col_q   <= in_col_d;
      in_slot_q  <= in_slot_d;
      out_row_q  <= out_row_d;
      out_col_q  <= out_col_d;
      out_slot_q <= out_slot_d;
      done_q     <= done_d;
    end
  end

endmodule

// ===== design/bbn_job_fifo.sv =====
module bbn_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bbn_pkg::job_t job_i,
  input  logic          pop_i,
  output bbn_pkg::job_t job_o,
  output logic          full_o,
  output logic          empty_o
);
  import bbn_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== design/bbn_back.sv =====
module bbn_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bbn_pkg::store_wr_t wr_i,
  input  logic               job_empty_i,
  input  bbn_pkg::job_t      job_i,
  output logic               job_pop_o,
  output logic               busy_o,
  output logic               empty_o,
  input  logic               pop_i,
  output bbn_pkg::out_item_t result_o
);
  import bbn_pkg::*;

  typedef enum logic [2:0] {StIdle, StSum, StTail, StPrep, StDiv, StOut} state_e;

  state_e                  state_q;
  job_t                    job_q;
  logic [TapW-1:0]         dr_q, dc_q;
  logic [SlotW-1:0]        slot_q;
  logic                    take_q;
  logic [SumW-1:0]         sr_q, sg_q, sb_q, qr_q, qg_q, qb_q;
  logic [RemW-1:0]         rr_q, rg_q, rb_q;
  logic [CntW-1:0]         cnt_q;
  logic [StepW-1:0]        step_q;
  logic [PixW-1:0]         rdata_q;
  logic [PixW-1:0]         mem [StoreDepth];
  out_item_t               out_q;
  logic                    out_valid_q;
  logic signed [DimW+1:0]  r_s, c_s;
  logic                    in_r, in_c, load;
  logic [AddrW-1:0]        rd_addr;
  logic [SlotW-1:0]        top_slot;
  logic [RemW+SumW-1:0]    nr, ng, nb;

  function automatic logic [RemW+SumW-1:0] div_step(logic [RemW-1:0] rem,
                                                    logic [SumW-1:0] quo,
                                                    logic [CntW-1:0] d);
    logic [RemW-1:0] sh;
    logic [RemW:0]   diff;
    logic [RemW+SumW-1:0] res;
    sh   = {rem[RemW-2:0], quo[SumW-1]};
    diff = {1'b0, sh} - {2'b00, d};
    if (!diff[RemW]) res = {diff[RemW-1:0], quo[SumW-2:0], 1'b1};
    else res = {sh, quo[SumW-2:0], 1'b0};
    return res;
  endfunction

  // Tap position inside the window, relative to the frame.
  assign r_s = $signed({2'b00, job_q.row}) + $signed({{(DimW+2-TapW){1'b0}}, dr_q})
               - $signed((DimW+2)'(Radius));
  assign c_s = $signed({{(DimW+2-ColW){1'b0}}, job_q.col})
               + $signed({{(DimW+2-TapW){1'b0}}, dc_q}) - $signed((DimW+2)'(Radius));
  assign in_r    = !r_s[DimW+1] && (r_s[DimW:0] < {1'b0, job_q.h});
  assign in_c    = !c_s[DimW+1] && (c_s[DimW:0] < {1'b0, job_q.w});
  assign rd_addr = {slot_q, c_s[ColW-1:0]};

  // Slot of the window's top row: row slot minus Radius, modulo the store rows.
  assign top_slot = (job_i.slot >= SlotW'(Radius)) ? job_i.slot - SlotW'(Radius)
                    : job_i.slot + SlotW'(StoreRows - Radius);

  assign nr = div_step(rr_q, qr_q, cnt_q);
  assign ng = div_step(rg_q, qg_q, cnt_q);
  assign nb = div_step(rb_q, qb_q, cnt_q);

  assign job_pop_o = (state_q == StIdle) && !job_empty_i;
  assign busy_o    = !job_empty_i || (state_q == StSum);
  assign load      = (state_q == StOut) && (!out_valid_q || pop_i);
  assign empty_o   = !out_valid_q;
  assign result_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem[wr_i.addr] <= wr_i.data;
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (take_q) begin
      sr_q  <= sr_q + SumW'(rdata_q[3*ChanW-1:2*ChanW]);
      sg_q  <= sg_q + SumW'(rdata_q[2*ChanW-1:ChanW]);
      sb_q  <= sb_q + SumW'(rdata_q[ChanW-1:0]);
      cnt_q <= cnt_q + CntW'(1);
    end
    case (state_q)
      StIdle: begin
        job_q  <= job_i;
        slot_q <= top_slot;
        dr_q   <= '0;
        dc_q   <= '0;
        sr_q   <= '0;
        sg_q   <= '0;
        sb_q   <= '0;
        cnt_q  <= '0;
      end
      StSum: begin
        if (dc_q == TapW'(WinSize - 1)) begin
          dc_q   <= '0;
          dr_q   <= dr_q + TapW'(1);
          slot_q <= slot_inc(slot_q);
        end else begin
          dc_q <= dc_q + TapW'(1);
        end
      end
      StPrep: begin
        qr_q   <= sr_q;
        qg_q   <= sg_q;
        qb_q   <= sb_q;
        rr_q   <= '0;
        rg_q   <= '0;
        rb_q   <= '0;
        step_q <= '0;
      end
      StDiv: begin
        {rr_q, qr_q} <= nr;
        {rg_q, qg_q} <= ng;
        {rb_q, qb_q} <= nb;
        step_q       <= step_q + StepW'(1);
      end
      default: begin
      end
    endcase
    if (load) begin
      out_q.red_out       <= qr_q[ChanW-1:0];
      out_q.green_out     <= qg_q[ChanW-1:0];
      out_q.blue_out      <= qb_q[ChanW-1:0];
      out_q.last_of_frame <= job_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      take_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      take_q <= (state_q == StSum) && in_r && in_c;
      if (pop_i && out_valid_q) out_valid_q <= 1'b0;
      if (load) out_valid_q <= 1'b1;
      case (state_q)
        StIdle: begin
          if (!job_empty_i) state_q <= StSum;
        end
        StSum: begin
          if (dc_q == TapW'(WinSize - 1) && dr_q == TapW'(WinSize - 1)) state_q <= StTail;
        end
        StTail: state_q <= StPrep;
        StPrep: state_q <= StDiv;
        StDiv: begin
          if (step_q == StepW'(SumW - 1)) state_q <= StOut;
        end
        StOut: begin
          if (load) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== design/box_blur_9x9_border_normalized_unit.sv =====
// Channel  | Direction | Handshake              | Beat
// pixels   | in        | push / full            | item_i   (opcode, red, green, blue)
// results  | out       | empty / pop            | result_o (red, green, blue, last)
// config   | in        | cfg_we_i, cfg_idx_i    | cfg_data_i (width, height)
//
// Per result, the back end walks all 81 window taps through the single read
// port of the line store, then runs a 15-step restoring divider per channel.
// The front runs at most two window jobs ahead; at a frame's first pixel it
// waits until the back end has finished reading the store.
// Reset clears all control state; the line store is not cleared.
module box_blur_9x9_border_normalized_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bbn_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bbn_pkg::DimW-1:0]    cfg_data_i,
  input  logic                        push,
  output logic                        full,
  input  bbn_pkg::in_item_t           item_i,
  output logic                        empty,
  input  logic                        pop,
  output bbn_pkg::out_item_t          result_o
);
  import bbn_pkg::*;

  store_wr_t wr;
  job_t      job_in, job_out;
  logic      job_push, job_pop, q_full, q_empty, busy;

  bbn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .item_i     (item_i),
    .hold_i     (busy),
    .q_full_i   (q_full),
    .full_o     (full),
    .job_push_o (job_push),
    .job_o      (job_in),
    .wr_o       (wr)
  );

  bbn_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .pop_i   (job_pop),
    .job_o   (job_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  bbn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .job_empty_i (q_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .busy_o      (busy),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule

// ===== design/bbn_checker.sv =====
`include "assert_macros.svh"

module bbn_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input bbn_pkg::out_item_t result_o
);

  // a waiting result neither vanishes nor changes
  `ASSERT_NEXT(a_res_held, !empty && !pop, !empty)
  `ASSERT_NEXT(a_res_stable, !empty && !pop, $stable(result_o))
  // out of reset nothing waits and the input side is open
  `ASSERT_NOW(a_rst_empty, !$past(rst_ni), empty)
  `ASSERT_NOW(a_rst_open, !$past(rst_ni), !full)

endmodule

bind box_blur_9x9_border_normalized_unit bbn_checker u_chk (.*);

// ===== verif/box_blur_9x9_border_normalized_checker.sv =====
`timescale 1ns / 1ps

module box_blur_9x9_border_normalized_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bbn_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bbn_pkg::DimW-1:0]    cfg_data_i,
  input  logic                        push_i,
  input  logic                        full_i,
  input  bbn_pkg::in_item_t           item_i,
  input  logic                        empty_i,
  input  logic                        pop_i,
  input  bbn_pkg::out_item_t          result_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  import bbn_pkg::*;

  logic [PixW-1:0] pix_rows [StoreRows][MaxWidth];
  int unsigned in_row, in_col, out_row, out_col;
  bit          draining;
  int unsigned width_reg, height_reg, frame_w, frame_h;
  out_item_t   blurred_q [$];

  function automatic out_item_t window_mean();
    out_item_t  res;
    int         r, c;
    int unsigned sr, sg, sb, cnt;
    logic [PixW-1:0] p;
    sr = 0; sg = 0; sb = 0; cnt = 0;
    for (int dr = -Radius; dr <= Radius; dr++) begin
      r = int'(out_row) + dr;
      if (r < 0 || r >= int'(frame_h)) continue;
      for (int dc = -Radius; dc <= Radius; dc++) begin
        c = int'(out_col) + dc;
        if (c < 0 || c >= int'(frame_w)) continue;
        p = pix_rows[r % StoreRows][c];
        sr += 32'(p[23:16]);
        sg += 32'(p[15:8]);
        sb += 32'(p[7:0]);
        cnt++;
      end
    end
    if (cnt == 0) cnt = 1;
    res.red_out       = ChanW'(sr / cnt);
    res.green_out     = ChanW'(sg / cnt);
    res.blue_out      = ChanW'(sb / cnt);
    res.last_of_frame = (out_row == frame_h - 1) && (out_col == frame_w - 1);
    if (res.last_of_frame) begin
      out_row = 0; out_col = 0; in_row = 0; in_col = 0;
      draining = 1'b0;
    end else if (out_col + 1 >= frame_w) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
    return res;
  endfunction

  function automatic void blur_step(in_item_t it);
    bit ready;
    if (it.opcode == OpDrain) begin
      if (draining) blurred_q.push_back(window_mean());
      return;
    end
    if (draining) return;
    if (in_row == 0 && in_col == 0) begin
      frame_w = (width_reg < MinSize) ? MinSize : (width_reg > MaxWidth) ? MaxWidth : width_reg;
      frame_h = (height_reg < MinSize) ? MinSize : height_reg;
    end
    pix_rows[in_row % StoreRows][in_col] = {it.red_in, it.green_in, it.blue_in};
    ready = (in_row > Radius) || (in_row == Radius && in_col >= Radius);
    if (in_col + 1 >= frame_w) begin
      in_col = 0;
      if (in_row + 1 >= frame_h) draining = 1'b1;
      else in_row++;
    end else begin
      in_col++;
    end
    if (ready) blurred_q.push_back(window_mean());
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      draining = 1'b0;
      width_reg = 256; height_reg = 256;
      frame_w = MinSize; frame_h = MinSize;
      blurred_q.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegFrameWidth) width_reg = 32'(cfg_data_i);
        else if (cfg_idx_i == RegFrameHeight) height_reg = 32'(cfg_data_i);
      end
      // pop before push: a result cannot leave in the cycle its pixel enters
      if (pop_i && !empty_i) begin
        if (blurred_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, result_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = blurred_q.pop_front();
          if (result_i !== want) begin
            $display("%0t: result mismatch, expected r=%0d g=%0d b=%0d last=%0b, actual r=%0d g=%0d b=%0d last=%0b",
                     $time, want.red_out, want.green_out, want.blue_out, want.last_of_frame,
                     result_i.red_out, result_i.green_out, result_i.blue_out,
                     result_i.last_of_frame);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (push_i && !full_i) blur_step(item_i);
    end
    pending_o <= blurred_q.size();
  end

endmodule

// ===== verif/box_blur_9x9_border_normalized_unit_test.sv =====
`timescale 1ns / 1ps

module box_blur_9x9_border_normalized_unit_test;
  import bbn_pkg::*;

  localparam int IdleLimit = 5000;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [DimW-1:0]    cfg_data_i;
  logic               push;
  logic               full;
  in_item_t           item_i;
  logic               empty;
  logic               pop;
  out_item_t          result_o;
  int                 fail_count;
  int                 pending;
  int                 burst_left;
  int                 idle_cycles;

  box_blur_9x9_border_normalized_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .push(push), .full(full), .item_i(item_i),
    .empty(empty), .pop(pop), .result_o(result_o)
  );

  box_blur_9x9_border_normalized_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .push_i(push), .full_i(full), .item_i(item_i),
    .empty_i(empty), .pop_i(pop), .result_i(result_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: long runs of steady pop, mixed at random with runs of random stalls
  initial begin
    int run;
    pop = 1'b0;
    forever begin
      run = $urandom_range(20, 400);
      if ($urandom_range(0, 2) == 0) begin
        repeat (run) @(negedge clk_i) pop <= 1'b1;
      end else begin
        repeat (run) @(negedge clk_i) pop <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAIL box_blur_9x9_border_normalized_unit");
      $finish;
    end
  end

  task automatic send_beat(input in_item_t it);
    if (burst_left == 0) begin
      @(negedge clk_i) push <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? 300 : $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk_i);
    push   <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
  endtask

  task automatic wait_idle();
    @(negedge clk_i) push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    // back end may still be busy on its last window
    repeat (250) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= DimW'(val);
    @(negedge clk_i) cfg_we_i <= 1'b0;
  endtask

  function automatic in_item_t make_pixel(input int k, input bit directed);
    in_item_t it;
    it.opcode = OpPixel;
    it.red_in = ChanW'($urandom);
    it.green_in = ChanW'($urandom);
    it.blue_in = ChanW'($urandom);
    if (directed) begin
      case (k % 4)
        0: begin
          it.red_in = 8'hff; it.green_in = 8'hff; it.blue_in = 8'hff;
        end
        1: begin
          it.red_in = 8'h00; it.green_in = 8'h00; it.blue_in = 8'h00;
        end
        2: begin
          it.red_in = 8'hff; it.green_in = 8'h00; it.blue_in = 8'h55;
        end
        default: ;
      endcase
    end else if ($urandom_range(0, 7) == 0) begin
      it.red_in = {8{it.red_in[0]}};
      it.green_in = {8{it.green_in[0]}};
      it.blue_in = {8{it.blue_in[0]}};
    end
    return it;
  endfunction

  task automatic run_frame(input int unsigned w_val, input int unsigned h_val,
                           input bit directed);
    int unsigned w, h;
    in_item_t    it;
    w = (w_val < MinSize) ? MinSize : (w_val > MaxWidth) ? MaxWidth : w_val;
    h = (h_val < MinSize) ? MinSize : h_val;
    wait_idle();
    write_reg(RegFrameWidth, w_val);
    write_reg(RegFrameHeight, h_val);
    for (int k = 0; k < int'(w * h); k++) begin
      // drain ticks mid-frame are ignored
      if (k > 0 && $urandom_range(0, 19) == 0) begin
        it = make_pixel(k, 1'b0);
        it.opcode = OpDrain;
        send_beat(it);
      end
      send_beat(make_pixel(k, directed));
    end
    for (int k = 0; k < int'(Radius * w + Radius); k++) begin
      // pixels while draining are ignored; never after the final drain
      if ($urandom_range(0, 19) == 0) send_beat(make_pixel(k, 1'b0));
      it = make_pixel(k, 1'b0);
      it.opcode = OpDrain;
      send_beat(it);
    end
  endtask

  initial begin
    in_item_t it;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = RegFrameWidth;
    cfg_data_i = '0;
    push       = 1'b0;
    item_i     = '0;
    burst_left = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // drain ticks with no frame in flight
    for (int k = 0; k < 3; k++) begin
      it = make_pixel(k, 1'b0);
      it.opcode = OpDrain;
      send_beat(it);
    end

    run_frame(0, 5, 1'b1);
    run_frame(24, 20, 1'b0);

    wait_idle();
    if (fail_count == 0) begin
      $display("PASS box_blur_9x9_border_normalized_unit");
    end else begin
      $display("FAIL box_blur_9x9_border_normalized_unit");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/bbn_pkg.sv
design/bbn_front.sv
design/bbn_job_fifo.sv
design/bbn_back.sv
design/box_blur_9x9_border_normalized_unit.sv
design/bbn_checker.sv
verif/box_blur_9x9_border_normalized_checker.sv
verif/box_blur_9x9_border_normalized_unit_test.sv
